/* rtl/cda_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date adder package
// Shared constants, leap, month-length and year-saturation helpers, and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int AMT_W   = 17;
   localparam int REQ_W   = 3;
   localparam int YMOD_W  = 9;

   localparam int YEAR_MIN        = -32768;
   localparam int YEAR_MAX        = 32767;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int LEAP_FEB_DAYS   = 29;
   localparam int GREG_CYCLE      = 400;

   // Bias that keeps the month total positive; it is a multiple of twelve.
   localparam int MDIV_YEAR_BIAS = 5462;
   localparam int MDIV_BIAS      = MDIV_YEAR_BIAS * MONTHS_PER_YEAR;
   // Ceiling of 2**17 / 3, exact for 16-bit dividends.
   localparam int DIV3_RECIP     = 43691;
   // Bias that makes any year positive; it is a multiple of 400.
   localparam int YMOD_BIAS      = 32800;
   // Ceiling of 2**16 / 25, exact for dividends up to 4698, which covers every biased year.
   localparam int DIV25_RECIP    = 2622;

   localparam logic [REQ_W-1:0] REQ_ADD_DAYS   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_SUB_DAYS   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ADD_MONTHS = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SUB_MONTHS = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ADD_YEARS  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_SUB_YEARS  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_LOAD       = 3'd6;
   localparam logic [REQ_W-1:0] REQ_NOP        = 3'd7;

   typedef struct packed {
      logic start;
      logic mdiv1;
      logic mdiv2;
      logic ymod1;
      logic ymod2;
      logic clamp;
      logic walk;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } status_type;

   function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
      is_leap = (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
                && (ymod != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      case (month) inside
         4'd2: begin
            month_len = leap ? DAY_W'(LEAP_FEB_DAYS) : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            month_len = 5'd30;
         end
         default: begin
            month_len = 5'd31;
         end
      endcase
   endfunction

   function automatic logic [YEAR_W-1:0] sat_year(input logic signed [18:0] y);
      if (y > 19'(YEAR_MAX)) begin
         sat_year = YEAR_W'(YEAR_MAX);
      end else if (y < 19'(YEAR_MIN)) begin
         sat_year = YEAR_W'(YEAR_MIN);
      end else begin
         sat_year = y[YEAR_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/cda_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date adder controller
// Sequences one request at a time through the datapath and owns both
// handshakes.
// ----------------------------------------------------------------------------
module cda_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [cda_pkg::REQ_W-1:0]  req_type,
   output logic                            req_stall,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output cda_pkg::cmd_type                cmd,
   input  wire cda_pkg::status_type        status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MDIV1 = 3'd1;
   localparam logic [2:0] ST_MDIV2 = 3'd2;
   localparam logic [2:0] ST_YMOD1 = 3'd3;
   localparam logic [2:0] ST_YMOD2 = 3'd4;
   localparam logic [2:0] ST_CLAMP = 3'd5;
   localparam logic [2:0] ST_WALK  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       can_publish;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign can_publish = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               unique case (req_type) inside
                  cda_pkg::REQ_ADD_DAYS, cda_pkg::REQ_SUB_DAYS: begin
                     state_in = ST_WALK;
                  end
                  cda_pkg::REQ_ADD_MONTHS, cda_pkg::REQ_SUB_MONTHS: begin
                     state_in = ST_MDIV1;
                  end
                  cda_pkg::REQ_ADD_YEARS, cda_pkg::REQ_SUB_YEARS, cda_pkg::REQ_LOAD: begin
                     state_in = ST_YMOD1;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MDIV1: begin
            cmd.mdiv1 = 1'b1;
            state_in  = ST_MDIV2;
         end
         ST_MDIV2: begin
            cmd.mdiv2 = 1'b1;
            state_in  = ST_YMOD1;
         end
         ST_YMOD1: begin
            cmd.ymod1 = 1'b1;
            state_in  = ST_YMOD2;
         end
         ST_YMOD2: begin
            cmd.ymod2 = 1'b1;
            state_in  = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_DONE;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.walk = 1'b1;
            end
         end
         ST_DONE: begin
            if (can_publish) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/cda_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date adder datapath
// Holds the current date, the year modulo 400 for leap decisions, the
// remaining day count of a walk and the output word registers.
// ----------------------------------------------------------------------------
module cda_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cda_pkg::cmd_type                cmd,
   output cda_pkg::status_type                  status,
   input  wire logic [cda_pkg::REQ_W-1:0]       req_type,
   input  wire logic signed [cda_pkg::AMT_W-1:0] req_amount,
   input  wire logic signed [cda_pkg::YEAR_W-1:0] req_load_year,
   input  wire logic [cda_pkg::MONTH_W-1:0]     req_load_month,
   input  wire logic [cda_pkg::DAY_W-1:0]       req_load_day,
   output logic signed [cda_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [cda_pkg::MONTH_W-1:0]          rsp_month_out,
   output logic [cda_pkg::DAY_W-1:0]            rsp_day_out
);

   // Current date and its year modulo 400; these agree except between a year change and the modulo steps after it.
   logic [cda_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [cda_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cda_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [cda_pkg::YMOD_W-1:0]  ymod_ff, ymod_in;

   logic [cda_pkg::AMT_W-1:0]   n_ff, n_in;
   logic                        neg_ff, neg_in;
   logic [17:0]                 t_ff, t_in;
   logic [31:0]                 prod_ff, prod_in;

   logic [cda_pkg::YEAR_W-1:0]  out_year_ff;
   logic [cda_pkg::MONTH_W-1:0] out_month_ff;
   logic [cda_pkg::DAY_W-1:0]   out_day_ff;

   logic [17:0]                 amt_ext;
   logic [17:0]                 delta;
   logic signed [18:0]          year_sum;
   logic [18:0]                 t_sum;
   logic [14:0]                 q12;
   logic [17:0]                 r12;
   logic signed [18:0]          year_mdiv;
   logic [16:0]                 ybias;
   logic [7:0]                  q400;
   logic [16:0]                 ymod_full;
   logic [cda_pkg::MONTH_W-1:0] load_month_c;
   logic [cda_pkg::DAY_W-1:0]   cur_len;
   logic [cda_pkg::DAY_W-1:0]   rem;
   logic [cda_pkg::YMOD_W-1:0]  ymod_next;
   logic [cda_pkg::YMOD_W-1:0]  ymod_prev;
   logic [cda_pkg::MONTH_W-1:0] prev_month;
   logic [cda_pkg::DAY_W-1:0]   prev_len;
   logic                        at_year_max;
   logic                        at_year_min;

   assign status.walk_done = (n_ff == '0);

   always_comb begin
      amt_ext   = {req_amount[cda_pkg::AMT_W-1], req_amount};
      // Odd request codes subtract.
      delta     = req_type[0] ? (18'd0 - amt_ext) : amt_ext;
      year_sum  = {{3{year_ff[cda_pkg::YEAR_W-1]}}, year_ff} + {delta[17], delta};
      t_sum     = {delta[17], delta} + 19'(month_ff) - 19'd1 + 19'(cda_pkg::MDIV_BIAS);

      q12       = prod_ff[31:17];
      r12       = t_ff - 18'(q12) * 18'(cda_pkg::MONTHS_PER_YEAR);
      year_mdiv = {{3{year_ff[cda_pkg::YEAR_W-1]}}, year_ff} + 19'(q12)
                  - 19'(cda_pkg::MDIV_YEAR_BIAS);

      ybias     = {year_ff[cda_pkg::YEAR_W-1], year_ff} + 17'(cda_pkg::YMOD_BIAS);
      q400      = prod_ff[23:16];
      ymod_full = ybias - 17'(q400) * 17'(cda_pkg::GREG_CYCLE);

      if (req_load_month == 4'd0) begin
         load_month_c = 4'd1;
      end else if (req_load_month > 4'(cda_pkg::MONTHS_PER_YEAR)) begin
         load_month_c = 4'(cda_pkg::MONTHS_PER_YEAR);
      end else begin
         load_month_c = req_load_month;
      end

      cur_len     = cda_pkg::month_len(month_ff, cda_pkg::is_leap(ymod_ff));
      rem         = cur_len - day_ff;
      ymod_next   = (ymod_ff == 9'(cda_pkg::GREG_CYCLE - 1)) ? 9'd0 : ymod_ff + 9'd1;
      ymod_prev   = (ymod_ff == 9'd0) ? 9'(cda_pkg::GREG_CYCLE - 1) : ymod_ff - 9'd1;
      prev_month  = (month_ff == 4'd1) ? 4'(cda_pkg::MONTHS_PER_YEAR) : month_ff - 4'd1;
      // Stepping back from January lands in the previous year.
      prev_len    = cda_pkg::month_len(prev_month,
                       cda_pkg::is_leap((month_ff == 4'd1) ? ymod_prev : ymod_ff));
      at_year_max = (year_ff == 16'(cda_pkg::YEAR_MAX));
      at_year_min = (year_ff == 16'(cda_pkg::YEAR_MIN));
   end

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      ymod_in  = ymod_ff;
      n_in     = n_ff;
      neg_in   = neg_ff;
      t_in     = t_ff;
      prod_in  = prod_ff;

      if (cmd.start) begin
         n_in   = delta[17] ? 17'(18'd0 - delta) : delta[16:0];
         neg_in = delta[17];
         t_in   = t_sum[17:0];
         case (req_type) inside
            cda_pkg::REQ_ADD_YEARS, cda_pkg::REQ_SUB_YEARS: begin
               year_in = cda_pkg::sat_year(year_sum);
            end
            cda_pkg::REQ_LOAD: begin
               year_in  = req_load_year;
               month_in = load_month_c;
               day_in   = req_load_day;
            end
            default: begin
            end
         endcase
      end else if (cmd.mdiv1) begin
         prod_in = 32'(t_ff[17:2]) * 32'(cda_pkg::DIV3_RECIP);
      end else if (cmd.mdiv2) begin
         year_in  = cda_pkg::sat_year(year_mdiv);
         month_in = r12[3:0] + 4'd1;
      end else if (cmd.ymod1) begin
         prod_in = 32'(ybias[16:4]) * 32'(cda_pkg::DIV25_RECIP);
      end else if (cmd.ymod2) begin
         ymod_in = ymod_full[cda_pkg::YMOD_W-1:0];
      end else if (cmd.clamp) begin
         if (day_ff == 5'd0) begin
            day_in = 5'd1;
         end else if (day_ff > cur_len) begin
            day_in = cur_len;
         end
      end else if (cmd.walk) begin
         if (!neg_ff) begin
            if (n_ff <= 17'(rem)) begin
               day_in = day_ff + n_ff[cda_pkg::DAY_W-1:0];
               n_in   = '0;
            end else if ((month_ff == 4'(cda_pkg::MONTHS_PER_YEAR)) && at_year_max) begin
               day_in = 5'd31;
               n_in   = '0;
            end else begin
               n_in   = n_ff - 17'(rem) - 17'd1;
               day_in = 5'd1;
               if (month_ff == 4'(cda_pkg::MONTHS_PER_YEAR)) begin
                  month_in = 4'd1;
                  year_in  = year_ff + 16'd1;
                  ymod_in  = ymod_next;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end else begin
            if (n_ff < 17'(day_ff)) begin
               day_in = day_ff - n_ff[cda_pkg::DAY_W-1:0];
               n_in   = '0;
            end else if ((month_ff == 4'd1) && at_year_min) begin
               day_in = 5'd1;
               n_in   = '0;
            end else begin
               n_in     = n_ff - 17'(day_ff);
               month_in = prev_month;
               day_in   = prev_len;
               if (month_ff == 4'd1) begin
                  year_in = year_ff - 16'd1;
                  ymod_in = ymod_prev;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= '0;
         month_ff <= 4'd1;
         day_ff   <= 5'd1;
         ymod_ff  <= '0;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         ymod_ff  <= ymod_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      neg_ff  <= neg_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      if (cmd.publish) begin
         out_year_ff  <= year_ff;
         out_month_ff <= month_ff;
         out_day_ff   <= day_ff;
      end
   end

   assign rsp_year_out  = out_year_ff;
   assign rsp_month_out = out_month_ff;
   assign rsp_day_out   = out_day_ff;

endmodule
`default_nettype wire

/* rtl/calendar_date_adder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load, add or subtract years pass the YMOD1, YMOD2, CLAMP and DONE states; months pass
// MDIV1 and MDIV2 before those; code 7 goes straight to DONE. Days pass WALK and DONE, and
// the walk moves one month per cycle. Throughput: one word in flight; the next word is
// taken once a result is in the output register. Reset: synchronous; the date returns to
// year 0, January 1.
// ----------------------------------------------------------------------------
// Calendar date adder core
// Keeps a Gregorian date and loads it or moves it by days, months or years per request.
// ----------------------------------------------------------------------------
module calendar_date_adder_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [cda_pkg::REQ_W-1:0]         req_type,
   input  wire logic signed [cda_pkg::AMT_W-1:0]  req_amount,
   input  wire logic signed [cda_pkg::YEAR_W-1:0] req_load_year,
   input  wire logic [cda_pkg::MONTH_W-1:0]       req_load_month,
   input  wire logic [cda_pkg::DAY_W-1:0]         req_load_day,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [cda_pkg::YEAR_W-1:0]      rsp_year_out,
   output logic [cda_pkg::MONTH_W-1:0]            rsp_month_out,
   output logic [cda_pkg::DAY_W-1:0]              rsp_day_out
);

   cda_pkg::cmd_type    cmd;
   cda_pkg::status_type status;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cda_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_amount     (req_amount),
      .req_load_year  (req_load_year),
      .req_load_month (req_load_month),
      .req_load_day   (req_load_day),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out)
   );

   // A taken word keeps the input side closed while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input side open right after a word was taken");

   // A new result appears only at the end of a request's work.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no request in flight");

   a_date_month_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_month_out >= 4'd1) && (rsp_month_out <= 4'd12)
                     && (rsp_day_out != 5'd0)))
      else $error("result month or day out of range");

   a_feb_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_month_out == 4'd2)) |-> (rsp_day_out <= 5'd29))
      else $error("February day beyond 29");

endmodule
`default_nettype wire
